>>> rtl/core/oaht_pkg.sv
// oaht_pkg: shared types and constants for the open addressing hash table
// depends on nothing; used by open_addressing_hash_table, oaht_checker and the test bench

package oaht_pkg;

	// default geometry
	localparam int SLOT_COUNT_DEF = 16;
	localparam int KEY_CHARS_DEF  = 8;

	// fixed port widths
	localparam int CMD_W   = 2;
	localparam int TEXT_W  = 64;
	localparam int LEN_W   = 4;
	localparam int VALUE_W = 8;
	localparam int INDEX_W = 4;
	localparam int CHAR_W  = 8;

	// shared multiplier operand width; (h + c) * c stays below 2^17
	localparam int MUL_W      = 17;
	localparam int HASH_SHIFT = MUL_W;

	// request commands; code 3 is unused, leaves the table unchanged and returns a failed result
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_FIND   = 2'd1,
		CMD_DELETE = 2'd2
	} cmd_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_QUO,
		ST_REM,
		ST_PROBE,
		ST_POST
	} state_t;

endpackage

>>> rtl/core/open_addressing_hash_table.sv
// open_addressing_hash_table: slot table with linear probing, keyed by short strings
// depends on oaht_pkg (types, constants)

// One request at a time. The key hash runs through one shared multiplier, in these
// steps for each key character: the product (h + c) * c, a quotient by the reciprocal
// of SLOT_COUNT, and the remainder with one correction step. Probing then reads one
// slot per cycle from the key/value memory, with the compare on the registered read
// in the following cycle. in_ready is low from acceptance until the result is loaded
// into the output register, which then holds it while the next item can already be
// accepted. Valid marks are flip-flops cleared by reset, so no clearing pass is needed.

module open_addressing_hash_table #(
	parameter int SLOT_COUNT = oaht_pkg::SLOT_COUNT_DEF,
	parameter int KEY_CHARS  = oaht_pkg::KEY_CHARS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [oaht_pkg::CMD_W-1:0]    cmd,
	input  logic [oaht_pkg::TEXT_W-1:0]   key_text,
	input  logic [oaht_pkg::LEN_W-1:0]    key_length,
	input  logic [oaht_pkg::VALUE_W-1:0]  entry_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          success,
	output logic [oaht_pkg::INDEX_W-1:0]  slot_index,
	output logic [oaht_pkg::VALUE_W-1:0]  value_out
);

	localparam int SLOT_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W     = $clog2(SLOT_COUNT + 1);
	localparam int KEY_W     = KEY_CHARS * oaht_pkg::CHAR_W;
	localparam int MUL_W     = oaht_pkg::MUL_W;
	localparam int RECIP     = (1 << oaht_pkg::HASH_SHIFT) / SLOT_COUNT;
	localparam int LEN_W     = oaht_pkg::LEN_W;
	localparam int VALUE_W   = oaht_pkg::VALUE_W;
	localparam int CHAR_W    = oaht_pkg::CHAR_W;

	oaht_pkg::state_t state_q, state_d;

	// request registers
	logic [oaht_pkg::CMD_W-1:0] cmd_q;
	logic [KEY_W-1:0]           key_q;
	logic [LEN_W-1:0]           len_q;
	logic [VALUE_W-1:0]         val_q;

	// hash datapath
	logic [KEY_W-1:0]     hsh_q;
	logic [LEN_W-1:0]     rem_q;
	logic [SLOT_BITS-1:0] h_q;
	logic [MUL_W-1:0]     p_q;
	logic [MUL_W-1:0]     q_q;
	logic [MUL_W-1:0]     mul_a, mul_b;
	logic [2*MUL_W-1:0]   prod;
	logic [MUL_W-1:0]     rem_raw, rem_fix;
	logic [CHAR_W-1:0]    hash_char;

	// probe datapath
	logic [SLOT_BITS-1:0] probe_q;
	logic [CNT_W-1:0]     issued_q;
	logic                 rd_live_q;
	logic                 rd_valid_q;
	logic [SLOT_BITS-1:0] rd_slot_q;
	logic [KEY_W-1:0]     rd_key_q;
	logic [LEN_W-1:0]     rd_len_q;
	logic [VALUE_W-1:0]   rd_val_q;
	logic                 rd_match, hit, miss, issue;

	// slot storage
	logic [SLOT_COUNT-1:0] slot_valid_q;
	logic [KEY_W-1:0]      key_mem [SLOT_COUNT];
	logic [LEN_W-1:0]      len_mem [SLOT_COUNT];
	logic [VALUE_W-1:0]    val_mem [SLOT_COUNT];

	// result staging and output register
	logic                 res_ok_q;
	logic [SLOT_BITS-1:0] res_slot_q;
	logic [VALUE_W-1:0]   res_val_q;
	logic                 out_valid_q;
	logic                 ok_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic [VALUE_W-1:0]   vout_q;

	// input conditioning: clamp length, zero bytes beyond it
	logic                 in_acc;
	logic [LEN_W-1:0]     len_c;
	logic [KEY_W-1:0]     key_c;

	assign in_ready = (state_q == oaht_pkg::ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign len_c    = (key_length > LEN_W'(KEY_CHARS)) ? LEN_W'(KEY_CHARS) : key_length;

	always_comb begin
		for (int b = 0; b < KEY_CHARS; b++) begin
			key_c[b*CHAR_W +: CHAR_W] = (LEN_W'(b) < len_c) ?
				key_text[b*CHAR_W +: CHAR_W] : '0;
		end
	end

	// shared multiplier and remainder correction
	assign hash_char = hsh_q[CHAR_W-1:0];
	assign prod      = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);
	assign rem_raw   = p_q - prod[MUL_W-1:0];
	assign rem_fix   = (rem_raw >= MUL_W'(SLOT_COUNT)) ? rem_raw - MUL_W'(SLOT_COUNT) : rem_raw;

	// probe compare on the registered read
	assign rd_match = (cmd_q == oaht_pkg::CMD_INSERT) ? !rd_valid_q :
		(rd_valid_q && (rd_len_q == len_q) && (rd_key_q == key_q));
	assign hit   = (state_q == oaht_pkg::ST_PROBE) && rd_live_q && rd_match;
	assign miss  = (state_q == oaht_pkg::ST_PROBE) && !rd_live_q &&
		(issued_q == CNT_W'(SLOT_COUNT));
	assign issue = (state_q == oaht_pkg::ST_PROBE) && !hit &&
		(issued_q != CNT_W'(SLOT_COUNT));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oaht_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and multiplier operand select
	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		case (state_q)
			oaht_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (!(cmd == oaht_pkg::CMD_INSERT || cmd == oaht_pkg::CMD_FIND ||
						cmd == oaht_pkg::CMD_DELETE)) begin
						state_d = oaht_pkg::ST_POST;
					end else if (len_c == '0) begin
						state_d = oaht_pkg::ST_PROBE;
					end else begin
						state_d = oaht_pkg::ST_MUL;
					end
				end
			end
			oaht_pkg::ST_MUL: begin
				mul_a   = MUL_W'(h_q) + MUL_W'(hash_char);
				mul_b   = MUL_W'(hash_char);
				state_d = oaht_pkg::ST_QUO;
			end
			oaht_pkg::ST_QUO: begin
				mul_a   = p_q;
				mul_b   = MUL_W'(RECIP);
				state_d = oaht_pkg::ST_REM;
			end
			oaht_pkg::ST_REM: begin
				mul_a   = q_q;
				mul_b   = MUL_W'(SLOT_COUNT);
				state_d = (rem_q == LEN_W'(1)) ? oaht_pkg::ST_PROBE : oaht_pkg::ST_MUL;
			end
			oaht_pkg::ST_PROBE: begin
				if (hit || miss) begin
					state_d = oaht_pkg::ST_POST;
				end
			end
			oaht_pkg::ST_POST: begin
				if (!out_valid_q || out_ready) begin
					state_d = oaht_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = oaht_pkg::ST_IDLE;
			end
		endcase
	end

	// request capture and hash iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			h_q   <= '0;
		end else begin
			if (in_acc) begin
				rem_q <= len_c;
				h_q   <= '0;
			end else if (state_q == oaht_pkg::ST_REM) begin
				rem_q <= rem_q - LEN_W'(1);
				h_q   <= SLOT_BITS'(rem_fix);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= cmd;
			key_q <= key_c;
			len_q <= len_c;
			val_q <= entry_value;
			hsh_q <= key_c;
		end
		if (state_q == oaht_pkg::ST_MUL) begin
			p_q <= prod[MUL_W-1:0];
		end
		if (state_q == oaht_pkg::ST_QUO) begin
			q_q <= prod[oaht_pkg::HASH_SHIFT +: MUL_W];
		end
		if (state_q == oaht_pkg::ST_REM) begin
			hsh_q <= hsh_q >> CHAR_W;
		end
	end

	// probe sequencing: one read issued per cycle from the home slot, wrapping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q   <= '0;
			issued_q  <= '0;
			rd_live_q <= 1'b0;
		end else begin
			rd_live_q <= issue;
			if (state_d == oaht_pkg::ST_PROBE && state_q != oaht_pkg::ST_PROBE) begin
				probe_q  <= (state_q == oaht_pkg::ST_REM) ? SLOT_BITS'(rem_fix) : '0;
				issued_q <= '0;
			end else if (issue) begin
				probe_q  <= (probe_q == SLOT_BITS'(SLOT_COUNT - 1)) ? '0 :
					probe_q + SLOT_BITS'(1);
				issued_q <= issued_q + CNT_W'(1);
			end
		end
	end

	// slot memory: registered read during probing, write on insert hit
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_key_q   <= key_mem[probe_q];
			rd_len_q   <= len_mem[probe_q];
			rd_val_q   <= val_mem[probe_q];
			rd_valid_q <= slot_valid_q[probe_q];
			rd_slot_q  <= probe_q;
		end
		if (hit && cmd_q == oaht_pkg::CMD_INSERT) begin
			key_mem[rd_slot_q] <= key_q;
			len_mem[rd_slot_q] <= len_q;
			val_mem[rd_slot_q] <= val_q;
		end
	end

	// valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (hit) begin
			case (cmd_q)
				oaht_pkg::CMD_INSERT: slot_valid_q[rd_slot_q] <= 1'b1;
				oaht_pkg::CMD_DELETE: slot_valid_q[rd_slot_q] <= 1'b0;
				default:              slot_valid_q[rd_slot_q] <= slot_valid_q[rd_slot_q];
			endcase
		end
	end

	// result staging
	always_ff @(posedge clk) begin
		if (hit) begin
			res_ok_q   <= 1'b1;
			res_slot_q <= rd_slot_q;
			res_val_q  <= (cmd_q == oaht_pkg::CMD_INSERT) ? '0 : rd_val_q;
		end else if (miss || (in_acc && state_d == oaht_pkg::ST_POST)) begin
			res_ok_q   <= 1'b0;
			res_slot_q <= '0;
			res_val_q  <= '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == oaht_pkg::ST_POST && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == oaht_pkg::ST_POST && (!out_valid_q || out_ready)) begin
			ok_q   <= res_ok_q;
			slot_q <= res_slot_q;
			vout_q <= res_val_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign success    = ok_q;
	assign slot_index = oaht_pkg::INDEX_W'(slot_q);
	assign value_out  = vout_q;

endmodule

>>> rtl/core/oaht_checker.sv
// oaht_checker: port-level assertions for open_addressing_hash_table
// depends on oaht_pkg (port widths); bound to the top level below

module oaht_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [oaht_pkg::CMD_W-1:0]    cmd,
	input logic [oaht_pkg::TEXT_W-1:0]   key_text,
	input logic [oaht_pkg::LEN_W-1:0]    key_length,
	input logic [oaht_pkg::VALUE_W-1:0]  entry_value,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          success,
	input logic [oaht_pkg::INDEX_W-1:0]  slot_index,
	input logic [oaht_pkg::VALUE_W-1:0]  value_out
);

	// a waiting input item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(cmd) && $stable(key_text) &&
		$stable(key_length) && $stable(entry_value))
		else $error("input item changed while waiting");

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(success) &&
		$stable(slot_index) && $stable(value_out))
		else $error("result item changed while stalled");

	// failure reports zero slot and value
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !success |-> slot_index == '0 && value_out == '0)
		else $error("failed item carries nonzero slot or value");

	// one item at a time: busy right after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while previous one in progress");

	// no result appears in the cycle after acceptance
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (.*);

>>> test/open_addressing_hash_table_test.sv
`timescale 1ns / 1ps
// open_addressing_hash_table_test: self-checking bench for the linear probing slot table
// depends on oaht_pkg and open_addressing_hash_table; predicts each result from its own table copy

module open_addressing_hash_table_test;

	localparam int TABLE_SLOTS   = oaht_pkg::SLOT_COUNT_DEF;
	localparam int KEY_BYTES     = oaht_pkg::KEY_CHARS_DEF;
	localparam int CMD_W         = oaht_pkg::CMD_W;
	localparam int TEXT_W        = oaht_pkg::TEXT_W;
	localparam int LEN_W         = oaht_pkg::LEN_W;
	localparam int VALUE_W       = oaht_pkg::VALUE_W;
	localparam int INDEX_W       = oaht_pkg::INDEX_W;
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
	localparam int RANDOM_ITEMS  = 450;
	localparam int POOL_DEPTH    = 24;
	localparam int HOLD_SPACING  = 180;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 3 * KEY_BYTES + TABLE_SLOTS + 20;
	localparam int RUN_LIMIT     = 400000;

	typedef struct packed {
		logic [CMD_W-1:0]   op;
		logic [TEXT_W-1:0]  text;
		logic [LEN_W-1:0]   len;
		logic [VALUE_W-1:0] val;
	} request_t;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] slot;
		logic [VALUE_W-1:0] val;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic success;
	logic [INDEX_W-1:0] slot_index;
	logic [VALUE_W-1:0] value_out;
	request_t offered = '0;

	// stimulus queue, awaited outcomes and keys worth looking up again
	request_t request_backlog[$];
	outcome_t awaited_outcomes[$];
	request_t key_pool[$];

	// table copy used for prediction
	logic               tbl_valid[TABLE_SLOTS] = '{default: 1'b0};
	logic [TEXT_W-1:0]  tbl_key[TABLE_SLOTS];
	logic [LEN_W-1:0]   tbl_len[TABLE_SLOTS];
	logic [VALUE_W-1:0] tbl_val[TABLE_SLOTS];

	int unsigned send_gap = 0;
	int unsigned recv_gap = 0;
	int unsigned hold_left = 0;
	int unsigned holds_done = 0;
	int unsigned accepted_total = 0;
	int unsigned results_seen = 0;
	int unsigned mismatch_total = 0;
	int unsigned cycle_count = 0;
	int unsigned n_placed = 0, n_full = 0, n_hit = 0, n_miss = 0, n_unused = 0;

	open_addressing_hash_table u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (offered.op),
		.key_text    (offered.text),
		.key_length  (offered.len),
		.entry_value (offered.val),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.success     (success),
		.slot_index  (slot_index),
		.value_out   (value_out)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// table behavior: trim the key, hash to a home slot, probe with wraparound
	function automatic outcome_t table_outcome(request_t rq);
		outcome_t res;
		int unsigned n, h, c, t, i;
		logic [TEXT_W-1:0] k;
		res = '0;
		n = (rq.len > KEY_BYTES) ? KEY_BYTES : rq.len;
		k = '0;
		h = 0;
		for (i = 0; i < n; i++) begin
			k[8*i +: 8] = rq.text[8*i +: 8];
			c = rq.text[8*i +: 8];
			h = ((h + c) * c) % TABLE_SLOTS;
		end
		case (rq.op)
			oaht_pkg::CMD_INSERT: begin
				for (i = 0; i < TABLE_SLOTS; i++) begin
					t = (h + i) % TABLE_SLOTS;
					if (!res.found && !tbl_valid[t]) begin
						tbl_valid[t] = 1'b1;
						tbl_key[t] = k;
						tbl_len[t] = LEN_W'(n);
						tbl_val[t] = rq.val;
						res.found = 1'b1;
						res.slot = INDEX_W'(t);
					end
				end
				if (res.found)
					n_placed++;
				else
					n_full++;
			end
			oaht_pkg::CMD_FIND, oaht_pkg::CMD_DELETE: begin
				for (i = 0; i < TABLE_SLOTS; i++) begin
					t = (h + i) % TABLE_SLOTS;
					if (!res.found && tbl_valid[t] && tbl_len[t] == n && tbl_key[t] == k) begin
						res.found = 1'b1;
						res.slot = INDEX_W'(t);
						res.val = tbl_val[t];
						if (rq.op == oaht_pkg::CMD_DELETE)
							tbl_valid[t] = 1'b0;
					end
				end
				if (res.found)
					n_hit++;
				else
					n_miss++;
			end
			default: n_unused++;
		endcase
		return res;
	endfunction

	function automatic int unsigned idle_draw(bit calm);
		return calm ? 0 : $urandom_range(0, 19);
	endfunction

	// a new key: mostly legal lengths, sometimes an oversize length field
	function automatic request_t fresh_key();
		request_t rq;
		rq = '0;
		rq.text = {$urandom, $urandom};
		rq.len = LEN_W'(($urandom_range(0, 9) < 6) ? $urandom_range(0, KEY_BYTES) :
			$urandom_range(0, 15));
		rq.val = VALUE_W'($urandom);
		return rq;
	endfunction

	// same key as src, with fresh junk above its length and an equivalent length code
	function automatic request_t same_key(request_t src);
		request_t rq;
		int unsigned n, i;
		rq = src;
		rq.text = {$urandom, $urandom};
		n = (src.len > KEY_BYTES) ? KEY_BYTES : src.len;
		for (i = 0; i < n; i++)
			rq.text[8*i +: 8] = src.text[8*i +: 8];
		rq.len = LEN_W'((n == KEY_BYTES) ? $urandom_range(KEY_BYTES, 15) : n);
		rq.val = VALUE_W'($urandom);
		return rq;
	endfunction

	task automatic queue_request(logic [CMD_W-1:0] op, logic [TEXT_W-1:0] text,
		logic [LEN_W-1:0] len, logic [VALUE_W-1:0] val);
		request_t rq;
		rq.op = op;
		rq.text = text;
		rq.len = len;
		rq.val = val;
		request_backlog.push_back(rq);
	endtask

	task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
		mismatch_total++;
		$display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
	endtask

	// request driver: predicts at acceptance, then waits its drawn gap before the next item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				awaited_outcomes.push_back(table_outcome(offered));
				accepted_total <= accepted_total + 1;
			end
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (request_backlog.size() != 0) begin
					offered <= request_backlog.pop_front();
					in_valid <= 1'b1;
					send_gap <= idle_draw((accepted_total % 80) < 20);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare against the oldest outcome, then stall a drawn number of cycles
	always @(posedge clk or negedge arst_n) begin : result_monitor
		outcome_t want;
		int unsigned wait_next;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			wait_next = recv_gap;
			if (out_valid && out_ready) begin
				if (awaited_outcomes.size() == 0) begin
					flag_mismatch("result with nothing pending", 0, 0);
				end else begin
					want = awaited_outcomes.pop_front();
					if (success !== want.found)
						flag_mismatch("success", success, want.found);
					if (slot_index !== want.slot)
						flag_mismatch("slot_index", slot_index, want.slot);
					if (value_out !== want.val)
						flag_mismatch("value_out", value_out, want.val);
				end
				results_seen++;
				wait_next = idle_draw((results_seen % 96) < 24);
			end else if (wait_next != 0) begin
				wait_next = wait_next - 1;
			end
			recv_gap <= wait_next;
			out_ready <= (wait_next == 0) && (hold_left == 0);
		end
	end

	// long receiver hold-offs so the output register fills and the input stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_done < 2 && accepted_total >= HOLD_SPACING * (holds_done + 1)) begin
			hold_left <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	// run limit
	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		request_t rq;
		int i, r;

		// empty key, oversize length, length mismatch, high-bit characters, unused code
		queue_request(oaht_pkg::CMD_INSERT, '1, 4'd0, 8'hff);
		queue_request(oaht_pkg::CMD_FIND, '0, 4'd0, 8'h00);
		queue_request(oaht_pkg::CMD_INSERT, '1, 4'd15, 8'h00);
		queue_request(oaht_pkg::CMD_FIND, '1, 4'd8, 8'h11);
		queue_request(oaht_pkg::CMD_FIND, '1, 4'd7, 8'h22);
		queue_request(oaht_pkg::CMD_INSERT, 64'h1234_5678_8381_8280, 4'd4, 8'h5a);
		queue_request(oaht_pkg::CMD_FIND, 64'hfedc_ba98_8381_8280, 4'd4, 8'h00);
		queue_request(CMD_NONE, 64'h0000_0000_8381_8280, 4'd4, 8'ha5);
		queue_request(oaht_pkg::CMD_DELETE, '1, 4'd8, 8'h00);
		queue_request(oaht_pkg::CMD_DELETE, '1, 4'd12, 8'h00);
		key_pool.push_back(request_backlog[0]);
		key_pool.push_back(request_backlog[5]);

		// fill the remaining 14 slots, then one insert and one lookup on a full table
		for (i = 1; i <= 14; i++) begin
			queue_request(oaht_pkg::CMD_INSERT, {$urandom, 24'h0, 8'(i)}, 4'd1,
				VALUE_W'($urandom));
			key_pool.push_back(request_backlog[request_backlog.size() - 1]);
		end
		queue_request(oaht_pkg::CMD_INSERT, 64'h0000_0000_0000_4040, 4'd2, 8'h77);
		queue_request(oaht_pkg::CMD_FIND, '0, 4'd1, 8'h00);

		// random traffic: mostly inserts, and lookups and deletes of recently inserted keys, some noise
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 35 || key_pool.size() == 0) begin
				if (r < 4 && key_pool.size() != 0)
					rq = same_key(key_pool[$urandom_range(0, key_pool.size() - 1)]);
				else
					rq = fresh_key();
				rq.op = oaht_pkg::CMD_INSERT;
				key_pool.push_back(rq);
				if (key_pool.size() > POOL_DEPTH)
					void'(key_pool.pop_front());
			end else if (r < 85) begin
				rq = same_key(key_pool[$urandom_range(0, key_pool.size() - 1)]);
				rq.op = (r < 60) ? oaht_pkg::CMD_FIND : oaht_pkg::CMD_DELETE;
			end else if (r < 95) begin
				rq = fresh_key();
				rq.op = (r % 2) ? oaht_pkg::CMD_FIND : oaht_pkg::CMD_DELETE;
			end else begin
				rq = fresh_key();
				rq.op = CMD_NONE;
			end
			request_backlog.push_back(rq);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (request_backlog.size() != 0 || in_valid || awaited_outcomes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d requests, %0d results checked, %0d receiver hold-offs",
			accepted_total, results_seen, holds_done);
		$display("inserts placed %0d, refused full %0d, lookups hit %0d, missed %0d, unused code %0d",
			n_placed, n_full, n_hit, n_miss, n_unused);
		if (mismatch_total == 0 && awaited_outcomes.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/oaht_pkg.sv
rtl/core/open_addressing_hash_table.sv
rtl/core/oaht_checker.sv
test/open_addressing_hash_table_test.sv
